// ----- src/cart_flash_command_controller_defines.svh -----
// Assertion macros used by the checker of the flash command controller.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CART_FLASH_COMMAND_CONTROLLER_DEFINES_SVH
`define CART_FLASH_COMMAND_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cfcc_pkg.sv -----
// Types, sizes and command codes of the cartridge flash command controller.
// No dependencies; used by the controller and by its checker.
`default_nettype none

package cfcc_pkg;

  // Storage size in halves; must be a power of two.
  localparam int unsigned STORE_HALVES = 65536;
  localparam int unsigned PAGE_BYTES   = 128;
  localparam int unsigned PAGE_HALVES  = PAGE_BYTES / 2;
  localparam int unsigned PAGE_COUNT   = STORE_HALVES / PAGE_HALVES;

  localparam int unsigned HALF_W   = 16;
  localparam int unsigned ADDR_W   = 27;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STORE_AW = $clog2(STORE_HALVES);
  localparam int unsigned SLOT_AW  = $clog2(PAGE_HALVES);
  localparam int unsigned PAGE_AW  = STORE_AW - SLOT_AW;

  typedef logic [HALF_W-1:0] half_t;

  // Bus access kinds.
  typedef enum logic [1:0] {
    CMD_READ_HALF  = 2'd0,
    CMD_READ_WORD  = 2'd1,
    CMD_WRITE_HALF = 2'd2,
    CMD_WRITE_WORD = 2'd3
  } cmd_e;

  // Flash command bytes, taken from write data bits 31:24.
  localparam logic [7:0] FC_SET_ERASE_PAGE = 8'h4b;
  localparam logic [7:0] FC_ENTER_ERASE    = 8'h78;
  localparam logic [7:0] FC_SET_WRITE_PAGE = 8'ha5;
  localparam logic [7:0] FC_ENTER_WRITE    = 8'hb4;
  localparam logic [7:0] FC_EXECUTE        = 8'hd2;
  localparam logic [7:0] FC_ENTER_STATUS   = 8'he1;
  localparam logic [7:0] FC_ENTER_READ     = 8'hf0;

  localparam logic [63:0] STATUS_ERASE  = 64'h1111_8008_00c2_001d;
  localparam logic [63:0] STATUS_WPAGE  = 64'h1111_8004_00c2_001d;
  localparam logic [63:0] STATUS_STATUS = 64'h1111_8001_00c2_001d;
  localparam logic [63:0] STATUS_READ   = 64'h1111_8004_f000_001d;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_STATUS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

endpackage

`default_nettype wire

// ----- src/cart_flash_command_controller.sv -----
// Cartridge flash command controller: bus accesses, command decoding, page programming.
// Depends on cfcc_pkg and cfcc_ram.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | to block  | in_valid_i, in_ready_o | command_i, address_i, write_data_i
//   out     | from block| out_valid_o, out_ready_i | read_data_o
//
// After reset the block fills the flash store with 0xffff, one half a cycle, with
// in_ready_o low. A write is taken in ST_IDLE; a read is taken in ST_IDLE and moves
// to ST_READ, where the store read data goes to the output register once it is free.
// An execute in erase or write mode moves to ST_EXEC and writes the selected page,
// one half a cycle, through the flash store write port.
// A read result sits in an output register; the next item is taken once the result is
// held there.
`default_nettype none

module cart_flash_command_controller (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [cfcc_pkg::ADDR_W-1:0] address_i,
  input  wire logic [cfcc_pkg::DATA_W-1:0] write_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [cfcc_pkg::DATA_W-1:0] read_data_o
);

  import cfcc_pkg::*;

  state_e                state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic [63:0]           status_q, status_d;
  logic [PAGE_AW-1:0]    page_q, page_d;
  logic [STORE_AW-1:0]   clr_q, clr_d;
  logic [SLOT_AW:0]      exec_q, exec_d;
  logic                  half_q, half_d;
  logic [1:0]            sel_q, sel_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_W-1:0]     rdata_q, rdata_d;

  logic                  in_fire;
  logic                  out_free;
  cmd_e                  cmd;
  logic [7:0]            fcmd;
  logic                  word_idx_zero;
  logic                  exec_start;
  logic                  exec_last;

  logic                  st_we, st_re;
  logic [STORE_AW-1:0]   st_waddr, st_raddr;
  half_t                 st_wdata, st_rdata;
  logic                  pb_we, pb_re;
  logic [SLOT_AW-1:0]    pb_waddr, pb_raddr;
  half_t                 pb_rdata;
  logic [SLOT_AW-1:0]    exec_wslot;
  logic [DATA_W-1:0]     result;

  assign cmd           = cmd_e'(command_i);
  assign fcmd          = write_data_i[31:24];
  assign word_idx_zero = (address_i[ADDR_W-1:2] == '0);
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_free      = !out_valid_q || out_ready_i;
  assign exec_start    = (cmd == CMD_WRITE_WORD) && !word_idx_zero && (fcmd == FC_EXECUTE)
                         && ((mode_q == MODE_ERASE) || (mode_q == MODE_WRITE));
  assign exec_last     = (exec_q == (SLOT_AW + 1)'(PAGE_HALVES));
  assign exec_wslot    = SLOT_AW'(exec_q - 1'b1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if ((cmd == CMD_READ_HALF) || (cmd == CMD_READ_WORD)) begin
            state_d = ST_READ;
          end else if (exec_start) begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EXEC: begin
        if (exec_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Read result by mode and address bits: a store or status half, or a status word.
  always_comb begin
    result = '0;
    if (half_q) begin
      case (mode_q)
        MODE_READ: result = {16'h0000, st_rdata};
        MODE_STATUS: begin
          case (sel_q)
            2'd0:    result = {16'h0000, status_q[63:48]};
            2'd1:    result = {16'h0000, status_q[47:32]};
            2'd2:    result = {16'h0000, status_q[31:16]};
            default: result = {16'h0000, status_q[15:0]};
          endcase
        end
        default: result = '0;
      endcase
    end else begin
      result = sel_q[1] ? status_q[31:0] : status_q[63:32];
    end
  end

  // Outputs, memory controls and register updates.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    mode_d      = mode_q;
    status_d    = status_q;
    page_d      = page_q;
    clr_d       = clr_q;
    exec_d      = exec_q;
    half_d      = half_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rdata_d     = rdata_q;
    st_we       = 1'b0;
    st_waddr    = clr_q;
    st_wdata    = 16'hffff;
    st_re       = 1'b0;
    st_raddr    = address_i[STORE_AW:1];
    pb_we       = 1'b0;
    pb_waddr    = address_i[SLOT_AW:1];
    pb_re       = 1'b0;
    pb_raddr    = exec_q[SLOT_AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        st_we = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        exec_d = '0;
        if (in_fire) begin
          half_d = (cmd == CMD_READ_HALF);
          sel_d  = address_i[2:1];
          case (cmd)
            CMD_READ_HALF: begin
              st_re = 1'b1;
            end
            CMD_WRITE_HALF: begin
              pb_we = (mode_q == MODE_WRITE);
            end
            CMD_WRITE_WORD: begin
              if (!word_idx_zero) begin
                case (fcmd)
                  FC_SET_ERASE_PAGE: begin
                    page_d = write_data_i[PAGE_AW-1:0];
                  end
                  FC_ENTER_ERASE: begin
                    mode_d   = MODE_ERASE;
                    status_d = STATUS_ERASE;
                  end
                  FC_SET_WRITE_PAGE: begin
                    page_d   = write_data_i[PAGE_AW-1:0];
                    status_d = STATUS_WPAGE;
                  end
                  FC_ENTER_WRITE: begin
                    mode_d = MODE_WRITE;
                  end
                  FC_ENTER_STATUS: begin
                    mode_d   = MODE_STATUS;
                    status_d = STATUS_STATUS;
                  end
                  FC_ENTER_READ: begin
                    mode_d   = MODE_READ;
                    status_d = STATUS_READ;
                  end
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rdata_d     = result;
        end
      end
      ST_EXEC: begin
        // The page buffer read runs one slot ahead of the store write.
        pb_re    = !exec_q[SLOT_AW];
        st_we    = (exec_q != '0);
        st_waddr = {page_q, exec_wslot};
        st_wdata = (mode_q == MODE_ERASE) ? 16'hffff : pb_rdata;
        exec_d   = exec_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= MODE_READ;
      status_q    <= '0;
      page_q      <= '0;
      clr_q       <= '0;
      exec_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      status_q    <= status_d;
      page_q      <= page_d;
      clr_q       <= clr_d;
      exec_q      <= exec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    half_q  <= half_d;
    sel_q   <= sel_d;
    rdata_q <= rdata_d;
  end

  cfcc_ram #(
    .WIDTH(HALF_W),
    .DEPTH(STORE_HALVES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  cfcc_ram #(
    .WIDTH(HALF_W),
    .DEPTH(PAGE_HALVES)
  ) u_page_buf (
    .clk_i  (clk_i),
    .we_i   (pb_we),
    .waddr_i(pb_waddr),
    .wdata_i(write_data_i[HALF_W-1:0]),
    .re_i   (pb_re),
    .raddr_i(pb_raddr),
    .rdata_o(pb_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/cfcc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module cfcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/cfcc_checker.sv -----
// Port-level checker for the flash command controller, bound to the top level.
// Depends on cfcc_pkg and cart_flash_command_controller_defines.svh.
`default_nettype none

`include "cart_flash_command_controller_defines.svh"

module cfcc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [1:0]                  command_i,
  input wire logic [cfcc_pkg::ADDR_W-1:0] address_i,
  input wire logic [cfcc_pkg::DATA_W-1:0] write_data_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [cfcc_pkg::DATA_W-1:0] read_data_o
);

  import cfcc_pkg::*;

  logic in_beat;
  logic read_beat;
  logic write_beat;

  assign in_beat    = in_valid_i && in_ready_o;
  assign read_beat  = in_beat && ((command_i == CMD_READ_HALF) || (command_i == CMD_READ_WORD));
  assign write_beat = in_beat && ((command_i == CMD_WRITE_HALF) || (command_i == CMD_WRITE_WORD));

  // A read taken while the output register is empty is answered without waiting for out_ready_i.
  `CFCC_ASSERT_NOW(a_read_answered, read_beat && !out_valid_o, ##2 out_valid_o, "read not answered")

  // A write taken while the output register is empty produces no result beat.
  `CFCC_ASSERT_NEXT(a_write_silent, write_beat && !out_valid_o, !out_valid_o, "write produced a result")

  // The block holds off further beats while a read is in flight.
  `CFCC_ASSERT_NEXT(a_read_blocks, read_beat, !in_ready_o, "beat taken during a read")

  // A stalled result keeps its value.
  `CFCC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(read_data_o), "stalled result changed")

  logic unused_ok;
  assign unused_ok = ^{address_i, write_data_i};

endmodule

bind cart_flash_command_controller cfcc_checker u_cfcc_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the cartridge flash command controller.
// Depends on cfcc_pkg and the controller RTL; bus beats are predicted in-house.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam logic [7:0]  STALL_PATTERN = 8'b1011_0110;
  localparam logic [7:0]  FLASH_CMDS [7] = '{FC_SET_ERASE_PAGE, FC_ENTER_ERASE,
                                             FC_SET_WRITE_PAGE, FC_ENTER_WRITE, FC_EXECUTE,
                                             FC_ENTER_STATUS, FC_ENTER_READ};

  typedef struct packed {
    cmd_e              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              known;
    logic [DATA_W-1:0] value;
  } beat_row_t;

  localparam int unsigned DIRECTED_ROWS = 27;
  localparam beat_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_READ_HALF,  27'h000_0000, 32'h0000_0000,             1'b1, 32'h0000_ffff},
    '{CMD_READ_HALF,  27'h7ff_fffe, 32'hffff_ffff,             1'b1, 32'h0000_ffff},
    '{CMD_WRITE_WORD, 27'h000_0003, {FC_ENTER_STATUS, 24'hffffff}, 1'b0, 32'h0},
    '{CMD_READ_WORD,  27'h000_0004, 32'h0000_0000,             1'b1, 32'h0000_0000},
    '{CMD_WRITE_WORD, 27'h7ff_ffff, {FC_ENTER_STATUS, 24'h0},  1'b0, 32'h0},
    '{CMD_READ_HALF,  27'h000_0000, 32'h0000_0000,             1'b1, 32'h0000_1111},
    '{CMD_READ_HALF,  27'h000_0002, 32'h0000_0000,             1'b1, 32'h0000_8001},
    '{CMD_READ_HALF,  27'h000_0004, 32'h0000_0000,             1'b1, 32'h0000_00c2},
    '{CMD_READ_HALF,  27'h7ff_fffe, 32'h0000_0000,             1'b1, 32'h0000_001d},
    '{CMD_READ_WORD,  27'h000_0000, 32'h0000_0000,             1'b1, 32'h1111_8001},
    '{CMD_READ_WORD,  27'h7ff_ffff, 32'h0000_0000,             1'b1, 32'h00c2_001d},
    '{CMD_WRITE_HALF, 27'h000_0002, 32'hffff_ffff,             1'b0, 32'h0},
    '{CMD_WRITE_WORD, 27'h000_0004, 32'h00ff_ffff,             1'b0, 32'h0},
    '{CMD_WRITE_WORD, 27'h000_0004, {FC_EXECUTE, 24'h0},       1'b0, 32'h0},
    '{CMD_WRITE_WORD, 27'h000_0008, {FC_SET_ERASE_PAGE, 24'hffffff}, 1'b0, 32'h0},
    '{CMD_WRITE_WORD, 27'h000_0008, {FC_ENTER_ERASE, 24'h0},   1'b0, 32'h0},
    '{CMD_READ_HALF,  27'h000_0000, 32'h0000_0000,             1'b1, 32'h0000_0000},
    '{CMD_READ_WORD,  27'h000_0000, 32'h0000_0000,             1'b1, 32'h1111_8008},
    '{CMD_WRITE_WORD, 27'h000_0008, {FC_EXECUTE, 24'h0},       1'b0, 32'h0},
    '{CMD_WRITE_WORD, 27'h000_0008, {FC_SET_WRITE_PAGE, 24'h000400}, 1'b0, 32'h0},
    '{CMD_READ_WORD,  27'h000_0000, 32'h0000_0000,             1'b1, 32'h1111_8004},
    '{CMD_WRITE_WORD, 27'h000_0008, {FC_ENTER_WRITE, 24'h0},   1'b0, 32'h0},
    '{CMD_WRITE_HALF, 27'h000_007e, 32'h0000_1234,             1'b0, 32'h0},
    '{CMD_READ_HALF,  27'h000_007e, 32'h0000_0000,             1'b1, 32'h0000_0000},
    '{CMD_WRITE_WORD, 27'h000_0008, {FC_ENTER_READ, 24'h0},    1'b0, 32'h0},
    '{CMD_READ_WORD,  27'h000_0004, 32'h0000_0000,             1'b1, 32'hf000_001d},
    '{CMD_READ_HALF,  27'h001_fffe, 32'h0000_0000,             1'b1, 32'h0000_ffff}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic [1:0]        command = CMD_READ_HALF;
  logic [ADDR_W-1:0] address = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] read_data_o;

  // Predicted flash state.
  mode_e                   flash_mode = MODE_READ;
  logic [63:0]             status_reg = '0;
  logic [PAGE_AW-1:0]      page_no = '0;
  logic [PAGE_AW-1:0]      last_programmed = '0;
  half_t                   page_buf [PAGE_HALVES];
  logic [PAGE_HALVES-1:0]  slots_filled = '0;
  half_t                   flash_img [STORE_HALVES];

  logic [DATA_W-1:0] pending_reads [$];
  int unsigned       mismatches = 0;
  int unsigned       useful_items = 0;
  int unsigned       ignored_items = 0;
  int unsigned       reads_checked = 0;
  int unsigned       pages_programmed = 0;
  int unsigned       pages_erased = 0;
  int unsigned       burst_left = 0;

  cart_flash_command_controller u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .command_i    (command),
    .address_i    (address),
    .write_data_i (write_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one accepted beat to the predicted flash state.
  function automatic void flash_access(input cmd_e cmd, input logic [ADDR_W-1:0] addr,
                                       input logic [DATA_W-1:0] data, output bit has_read,
                                       output logic [DATA_W-1:0] rd, output bit effective);
    logic [1:0] sel;
    int         i;
    has_read  = 1'b0;
    rd        = '0;
    effective = 1'b1;
    sel       = addr[2:1];
    case (cmd)
      CMD_READ_HALF: begin
        has_read = 1'b1;
        if (flash_mode == MODE_READ) begin
          rd = {16'h0, flash_img[addr[STORE_AW:1]]};
        end else if (flash_mode == MODE_STATUS) begin
          rd = {16'h0, status_reg[63 - 16 * sel -: 16]};
        end
      end
      CMD_READ_WORD: begin
        has_read = 1'b1;
        rd = addr[2] ? status_reg[31:0] : status_reg[63:32];
      end
      CMD_WRITE_HALF: begin
        if (flash_mode == MODE_WRITE) begin
          page_buf[addr[SLOT_AW:1]]     = data[15:0];
          slots_filled[addr[SLOT_AW:1]] = 1'b1;
        end else begin
          effective = 1'b0;
        end
      end
      default: begin
        if (addr[ADDR_W-1:2] == '0) begin
          effective = 1'b0;
        end else begin
          case (data[31:24])
            FC_SET_ERASE_PAGE: page_no = PAGE_AW'(data[15:0] % PAGE_COUNT);
            FC_ENTER_ERASE: begin
              flash_mode = MODE_ERASE;
              status_reg = STATUS_ERASE;
            end
            FC_SET_WRITE_PAGE: begin
              page_no    = PAGE_AW'(data[15:0] % PAGE_COUNT);
              status_reg = STATUS_WPAGE;
            end
            FC_ENTER_WRITE: flash_mode = MODE_WRITE;
            FC_EXECUTE: begin
              if (flash_mode == MODE_ERASE || flash_mode == MODE_WRITE) begin
                for (i = 0; i < PAGE_HALVES; i++) begin
                  flash_img[page_no * PAGE_HALVES + i] =
                    (flash_mode == MODE_ERASE) ? 16'hffff : page_buf[i];
                end
                if (flash_mode == MODE_ERASE) begin
                  pages_erased++;
                end else begin
                  pages_programmed++;
                  last_programmed = page_no;
                end
              end else begin
                effective = 1'b0;
              end
            end
            FC_ENTER_STATUS: begin
              flash_mode = MODE_STATUS;
              status_reg = STATUS_STATUS;
            end
            FC_ENTER_READ: begin
              flash_mode = MODE_READ;
              status_reg = STATUS_READ;
            end
            default: effective = 1'b0;
          endcase
        end
      end
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] word_addr();
    logic [ADDR_W-3:0] idx;
    idx = ($urandom_range(0, 3) == 0) ? (ADDR_W-2)'($urandom_range(1, 8))
                                      : (ADDR_W-2)'($urandom_range(1, 2**(ADDR_W-2) - 1));
    return {idx, 2'($urandom)};
  endfunction

  // Byte address of a half within a page, with random bits above the store size.
  function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_AW-1:0] page,
                                                 input logic [SLOT_AW-1:0] slot);
    logic [ADDR_W-STORE_AW-2:0] hi;
    hi = (ADDR_W-STORE_AW-1)'($urandom);
    return {hi, page, slot, 1'($urandom)};
  endfunction

  function automatic logic [DATA_W-1:0] cmd_word(input logic [7:0] code, input logic [15:0] arg);
    return {code, 8'($urandom), arg};
  endfunction

  task automatic send_beat(input cmd_e cmd, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, input bit known = 1'b0,
                           input logic [DATA_W-1:0] value = '0);
    bit                has_read;
    bit                effective;
    logic [DATA_W-1:0] predicted;
    int unsigned       gap;
    // Executing a write from a partly filled page buffer is never allowed.
    if (cmd == CMD_WRITE_WORD && addr[ADDR_W-1:2] != '0 && data[31:24] == FC_EXECUTE &&
        flash_mode == MODE_WRITE && !(&slots_filled)) begin
      data[31:24] = FC_ENTER_READ;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    command    <= cmd;
    address    <= addr;
    write_data <= data;
    do @(posedge clk_i); while (!in_ready_o);
    flash_access(cmd, addr, data, has_read, predicted, effective);
    if (has_read) begin
      pending_reads.push_back(known ? value : predicted);
    end
    if (effective) begin
      useful_items++;
    end else begin
      ignored_items++;
    end
  endtask

  // Receiver: checks each read beat and stalls in a pattern of its own.
  initial begin
    int unsigned       rx_mode;
    int unsigned       mode_left;
    int unsigned       stall_left;
    int unsigned       pat_idx;
    logic [DATA_W-1:0] want;
    mode_left  = 0;
    stall_left = 0;
    pat_idx    = 0;
    rx_mode    = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        if (pending_reads.size() == 0) begin
          $error("read_data beat with no read pending: actual %h", read_data_o);
          mismatches++;
        end else begin
          want = pending_reads.pop_front();
          reads_checked++;
          if (read_data_o !== want) begin
            $error("read_data mismatch: expected %h, actual %h", want, read_data_o);
            mismatches++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(100, 400);
      end
      mode_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: begin
          out_ready <= STALL_PATTERN[pat_idx % 8];
          pat_idx++;
        end
        default: begin
          if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL cart_flash_command_controller");
    $finish;
  end

  initial begin
    int unsigned       pick;
    int unsigned       n;
    int unsigned       k;
    bit                fill_all;
    logic [15:0]       arg;
    logic [DATA_W-1:0] data;
    foreach (flash_img[j]) flash_img[j] = 16'hffff;
    foreach (page_buf[j]) page_buf[j] = 16'h0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r]) begin
      send_beat(DIRECTED[r].cmd, DIRECTED[r].addr, DIRECTED[r].data,
                DIRECTED[r].known, DIRECTED[r].value);
    end

    while (useful_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Program a page: select it, enter write mode, fill slots, execute, read back.
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_SET_WRITE_PAGE, 16'($urandom)));
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_ENTER_WRITE, 16'($urandom)));
        fill_all = !(&slots_filled);
        n = fill_all ? PAGE_HALVES : $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
          send_beat(CMD_WRITE_HALF,
                    page_addr(PAGE_AW'($urandom), fill_all ? SLOT_AW'(k) : SLOT_AW'($urandom)),
                    $urandom);
          if ($urandom_range(0, 7) == 0) send_beat(CMD_READ_WORD, ADDR_W'($urandom), $urandom);
        end
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_EXECUTE, 16'($urandom)));
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_ENTER_READ, 16'($urandom)));
        repeat ($urandom_range(2, 6)) begin
          send_beat(CMD_READ_HALF, page_addr(page_no, SLOT_AW'($urandom)), $urandom);
        end
      end else if (pick < 65) begin
        // Erase a page, often the one programmed last, then read it back.
        arg = 16'($urandom);
        if ($urandom_range(0, 1) == 1) arg[PAGE_AW-1:0] = last_programmed;
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_SET_ERASE_PAGE, arg));
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_ENTER_ERASE, 16'($urandom)));
        if ($urandom_range(0, 1) == 1) send_beat(CMD_READ_HALF, ADDR_W'($urandom), $urandom);
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_EXECUTE, 16'($urandom)));
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_ENTER_READ, 16'($urandom)));
        repeat ($urandom_range(2, 6)) begin
          send_beat(CMD_READ_HALF, page_addr(page_no, SLOT_AW'($urandom)), $urandom);
        end
      end else if (pick < 75) begin
        send_beat(CMD_WRITE_WORD, word_addr(), cmd_word(FC_ENTER_STATUS, 16'($urandom)));
        repeat ($urandom_range(2, 6)) begin
          send_beat($urandom_range(0, 1) ? CMD_READ_WORD : CMD_READ_HALF,
                    ADDR_W'($urandom), $urandom);
        end
      end else begin
        // Unstructured beats; about half of them carry a known command byte.
        repeat ($urandom_range(1, 8)) begin
          data = $urandom;
          if ($urandom_range(0, 1) == 1) data[31:24] = FLASH_CMDS[$urandom_range(0, 6)];
          send_beat(cmd_e'($urandom_range(0, 3)), ADDR_W'($urandom), data);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (2 * PAGE_HALVES) @(posedge clk_i);

    $display("Ran %0d bus beats (%0d with no effect) and checked %0d read results.",
             useful_items + ignored_items, ignored_items, reads_checked);
    $display("Pages programmed: %0d, pages erased: %0d.", pages_programmed, pages_erased);
    if (mismatches == 0) begin
      $display("PASS cart_flash_command_controller");
    end else begin
      $display("FAIL cart_flash_command_controller");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/cfcc_pkg.sv
src/cfcc_ram.sv
src/cart_flash_command_controller.sv
src/cfcc_checker.sv
test/tb.sv
